/* hdl/b64e_pkg.sv */
`default_nettype none

package b64e_pkg;

  // Work queue depth between the byte front end and the character back end
  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_DIGIT_0 = 7'h30;
  localparam logic [6:0] ASCII_DASH    = 7'h2D;
  localparam logic [6:0] ASCII_USCORE  = 7'h5F;

  localparam logic [5:0] SEXT_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXT_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXT_DASH       = 6'd62;

  // Position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } b64e_phase_t;

  // One queued work entry: one or two sextets for the back end
  typedef struct packed {
    logic [5:0] sext0;
    logic [5:0] sext1;
    logic       two;   // second sextet present
    logic       last;  // second sextet ends the message
  } b64e_work_t;

  function automatic logic [6:0] sextet_to_char(input logic [5:0] s);
    logic [6:0] c;
    priority if (s < SEXT_LOWER_BASE) begin
      c = ASCII_UPPER_A + {1'b0, s};
    end else if (s < SEXT_DIGIT_BASE) begin
      c = ASCII_LOWER_A + {1'b0, s - SEXT_LOWER_BASE};
    end else if (s < SEXT_DASH) begin
      c = ASCII_DIGIT_0 + {1'b0, s - SEXT_DIGIT_BASE};
    end else if (s == SEXT_DASH) begin
      c = ASCII_DASH;
    end else begin
      c = ASCII_USCORE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/base64url_stream_encoder.sv */
`default_nettype none

// Unpadded base64url encoder for a byte stream.
// Input: one message byte per transfer on in_tdata; in_tlast marks the
// final byte of a message. Output: one ASCII character per transfer on
// out_tdata[6:0]; out_tlast marks the final character of the message and
// out_tuser[0] marks the last character produced by a given input byte.
// Bytes one and two of each three-byte group give one character each; the
// third byte, and any final byte that leaves bits over, gives two.
// Each byte passes through the work queue and then the output register
// before its first character is offered. One character per cycle leaves
// the output register while out_tready stays high, so a byte that yields
// two characters takes longer; the single character port sets this.
// A work queue of DEPTH entries sits between byte classification and
// character output, so in_tready stays high while the receiver stalls
// until the queue fills; a stalled character holds on out_tdata.
// Synchronous reset (rst_n low) restarts the group at its first byte and
// empties the queue and the output register.
module base64url_stream_encoder
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] out_char, [7] zero
  output logic            out_tlast,  // last_char
  output logic [0:0]      out_tuser   // [0] run_end
);

  b64e_work_t push_data;
  b64e_work_t pop_data;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic [6:0] char_w;
  logic       end_w;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  b64e_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (pop_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_w),
    .last_char (out_tlast),
    .run_end   (end_w)
  );

  assign out_tdata = {1'b0, char_w};
  assign out_tuser = end_w;

endmodule

`default_nettype wire

/* hdl/b64e_front.sv */
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output b64e_work_t      q_data
);

  b64e_phase_t phase_r, phase_nxt;
  logic [3:0]  carry_r, carry_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // Split the byte into sextets against the leftover bits of the group
  always_comb begin
    phase_nxt    = PH_FIRST;
    carry_nxt    = '0;
    q_data.sext0 = data_byte[7:2];
    q_data.sext1 = {data_byte[1:0], 4'b0000};
    q_data.two   = final_byte;
    q_data.last  = final_byte;
    unique case (phase_r)
      PH_SECOND: begin
        q_data.sext0 = {carry_r[1:0], data_byte[7:4]};
        q_data.sext1 = {data_byte[3:0], 2'b00};
        if (!final_byte) begin
          phase_nxt = PH_THIRD;
          carry_nxt = data_byte[3:0];
        end
      end
      PH_THIRD: begin
        q_data.sext0 = {carry_r[3:0], data_byte[7:6]};
        q_data.sext1 = data_byte[5:0];
        q_data.two   = 1'b1;
      end
      default: begin
        if (!final_byte) begin
          phase_nxt = PH_SECOND;
          carry_nxt = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/b64e_queue.sv */
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire b64e_work_t  push_data,
  output logic             full,
  input  wire logic        pop,
  output b64e_work_t       pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_work_t     mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* hdl/b64e_back.sv */
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire b64e_work_t  q_data,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char,
  output logic             last_char,
  output logic             run_end
);

  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_end_r, out_end_nxt;
  logic       pend_r, pend_nxt;
  logic [5:0] pend_sext_r, pend_sext_nxt;
  logic       pend_last_r, pend_last_nxt;
  logic       load_ok;

  assign load_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign last_char = out_last_r;
  assign run_end   = out_end_r;

  always_comb begin
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_end_nxt   = out_end_r;
    pend_nxt      = pend_r;
    pend_sext_nxt = pend_sext_r;
    pend_last_nxt = pend_last_r;
    if (load_ok) begin
      if (pend_r) begin
        // send the held second character of the entry
        out_valid_nxt = 1'b1;
        out_char_nxt  = sextet_to_char(pend_sext_r);
        out_last_nxt  = pend_last_r;
        out_end_nxt   = 1'b1;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_char_nxt  = sextet_to_char(q_data.sext0);
        out_last_nxt  = 1'b0;
        out_end_nxt   = !q_data.two;
        pend_nxt      = q_data.two;
        pend_sext_nxt = q_data.sext1;
        pend_last_nxt = q_data.last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_end_r   <= out_end_nxt;
    pend_sext_r <= pend_sext_nxt;
    pend_last_r <= pend_last_nxt;
  end

  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second character held with no first character out");

  a_pend_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r) |-> (!out_end_r && !out_last_r))
    else $error("first character of a pair flagged as end");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       run_end;
  } char_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [0:0] out_tuser;

  // Alphabet in reading order: character 0 sits in the top byte
  logic [8*64-1:0] alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  b64e_phase_t  enc_phase;
  logic [3:0]   enc_carry;
  char_result_t pending_chars[$];

  int          tx_gap_pct;
  int          rx_stall_pct;
  logic        hold_off;
  int          errors;
  int unsigned cycle_count;

  base64url_stream_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[base64url_stream_encoder] ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(30, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [7:0] c;
    c = alphabet[8*(63 - s) +: 8];
    return c[6:0];
  endfunction

  function automatic void push_char(input logic [5:0] s, input logic last,
                                    input logic run_end);
    char_result_t r;
    r.ch      = sextet_char(s);
    r.last    = last;
    r.run_end = run_end;
    pending_chars.push_back(r);
  endfunction

  // Advance the encoder state by one byte and queue the characters it yields
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (enc_phase)
      PH_SECOND: begin
        if (fin) begin
          push_char({enc_carry[1:0], b[7:4]}, 1'b0, 1'b0);
          push_char({b[3:0], 2'b00}, 1'b1, 1'b1);
          enc_phase = PH_FIRST;
          enc_carry = '0;
        end else begin
          push_char({enc_carry[1:0], b[7:4]}, 1'b0, 1'b1);
          enc_carry = b[3:0];
          enc_phase = PH_THIRD;
        end
      end
      PH_THIRD: begin
        push_char({enc_carry, b[7:6]}, 1'b0, 1'b0);
        push_char(b[5:0], fin, 1'b1);
        enc_phase = PH_FIRST;
        enc_carry = '0;
      end
      default: begin
        if (fin) begin
          push_char(b[7:2], 1'b0, 1'b0);
          push_char({b[1:0], 4'b0000}, 1'b1, 1'b1);
          enc_phase = PH_FIRST;
          enc_carry = '0;
        end else begin
          push_char(b[7:2], 1'b0, 1'b1);
          enc_carry = {2'b00, b[1:0]};
          enc_phase = PH_SECOND;
        end
      end
    endcase
  endfunction

  // Output receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    char_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: tdata=%h tlast=%b tuser=%b",
                 $realtime, out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        exp_r = pending_chars.pop_front();
        if (out_tdata !== {1'b0, exp_r.ch}) begin
          $display("%0t: tdata mismatch: expected %h, actual %h",
                   $realtime, {1'b0, exp_r.ch}, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_r.last) begin
          $display("%0t: tlast mismatch: expected %b, actual %b",
                   $realtime, exp_r.last, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== exp_r.run_end) begin
          $display("%0t: tuser mismatch: expected %b, actual %b",
                   $realtime, exp_r.run_end, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_byte(b, fin);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // Drop valid and wait until every queued character has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Field extremes, alphabet ends, flush after one and two bytes,
  // a final byte completing a group, and a message spanning groups
  task automatic test_directed();
    logic [8:0] items [21] = '{
      {1'b1, 8'h00},
      {1'b1, 8'hFF},
      {1'b0, 8'hFF}, {1'b1, 8'hFF},
      {1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE},
      {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'h00},
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h01},
      {1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b0, 8'h80}, {1'b1, 8'h7F}
    };
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (items[i]) send_byte(items[i][7:0], items[i][8]);
    drain();
  endtask

  task automatic test_random_messages(input int n_items);
    int sent;
    int len;
    sent = 0;
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 1);
      send_message(len);
      sent += len;
    end
    drain();
  endtask

  task automatic test_full_rate(input int n_items);
    int sent;
    int len;
    sent = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    while (sent < n_items) begin
      len = $urandom_range(12, 1);
      send_message(len);
      sent += len;
    end
    drain();
  endtask

  task automatic test_slow_receiver(input int n_items);
    int sent;
    int len;
    sent = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 60;
    while (sent < n_items) begin
      len = $urandom_range(10, 1);
      send_message(len);
      sent += len;
    end
    drain();
  endtask

  // Hold the receiver off while bytes keep coming so the input stalls
  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_off     = 1'b1;
    repeat (3) send_message(8);
    drain();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    hold_off    = 1'b0;
    tx_gap_pct  = 0;
    rx_stall_pct = 0;
    errors      = 0;
    cycle_count = 0;
    enc_phase   = PH_FIRST;
    enc_carry   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_rate(60);
    test_random_messages(260);
    test_backpressure();
    test_slow_receiver(50);

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[base64url_stream_encoder] OK");
    end else begin
      $display("[base64url_stream_encoder] ERROR");
    end
    $finish;
  end

endmodule
